// File: hw/rtl/pinned_lru_record_pool_macros.svh
// ----------------------------------------------------------------------------
// pinned lru record pool assertion macros
// shared concurrent assertion forms used by the controller and datapath
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_RECORD_POOL_MACROS_SVH
`define PINNED_LRU_RECORD_POOL_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plrp assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plrp assertion failed");

`endif

// File: hw/rtl/plrp_pkg.sv
// ----------------------------------------------------------------------------
// plrp_pkg
// types and constants shared by the record pool controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package plrp_pkg;

    localparam int REC_W   = 8;
    localparam int COUNT_W = 9;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_FREE    = 2'd1,
        OP_ENQUEUE = 2'd2,
        OP_DEQUEUE = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/plrp_cmd_if.sv
// ----------------------------------------------------------------------------
// plrp_cmd_if
// operation channel: opcode and record index with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface plrp_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] record;

    modport source (output valid, output opcode, output record, input ready);
    modport sink   (input valid, input opcode, input record, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/plrp_res_if.sv
// ----------------------------------------------------------------------------
// plrp_res_if
// result channel: eviction report, used count and queue state with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface plrp_res_if;
    logic       valid;
    logic       ready;
    logic       evict_valid;
    logic [7:0] evicted_record;
    logic [8:0] used_count;
    logic       queue_empty;

    modport source (output valid, output evict_valid, output evicted_record,
                    output used_count, output queue_empty, input ready);
    modport sink   (input valid, input evict_valid, input evicted_record,
                    input used_count, input queue_empty, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/plrp_cfg_if.sv
// ----------------------------------------------------------------------------
// plrp_cfg_if
// configuration write channel for the target size register
// ----------------------------------------------------------------------------
`default_nettype none

interface plrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] target_size;

    modport source (output valid, output target_size, input ready);
    modport sink   (input valid, input target_size, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/plrp_ram.sv
// ----------------------------------------------------------------------------
// plrp_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module plrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/plrp_ctrl.sv
// ----------------------------------------------------------------------------
// plrp_ctrl
// two-state sequencer: accept an operation, then commit it to the datapath
// ----------------------------------------------------------------------------
`default_nettype none

`include "pinned_lru_record_pool_macros.svh"

module plrp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output plrp_pkg::t_ctrl_cmd   o_cmd,
    input  plrp_pkg::t_dp_status  i_status
);

    import plrp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the beat
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_EXEC: begin
                o_cmd.commit = i_status.out_free;
            end
        endcase
    end

    `PLRP_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, o_cmd.accept, r_state == ST_EXEC)
    `PLRP_ASSERT_NXT(a_commit_to_idle, i_clk, i_rst_n, o_cmd.commit, r_state == ST_IDLE)
    `PLRP_ASSERT_IMP(a_no_accept_commit, i_clk, i_rst_n, 1'b1, !(o_ready && o_cmd.commit))

endmodule

`default_nettype wire

// File: hw/rtl/plrp_datapath.sv
// ----------------------------------------------------------------------------
// plrp_datapath
// link memories, queue end registers, used count and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "pinned_lru_record_pool_macros.svh"

module plrp_datapath #(
    parameter int RECORDS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plrp_pkg::t_ctrl_cmd   i_cmd,
    output plrp_pkg::t_dp_status  o_status,
    input  logic [1:0]            i_opcode,
    input  logic [7:0]            i_record,
    plrp_cfg_if.sink              i_cfg,
    plrp_res_if.source            o_res
);

    import plrp_pkg::*;

    localparam int AW = $clog2(RECORDS);
    localparam logic [31:0] RECORDS_U = 32'(RECORDS);
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'((RECORDS < 511) ? RECORDS : 511);

    function automatic logic rec_ok(input logic [REC_W-1:0] v);
        return 32'(v) < RECORDS_U;
    endfunction

    // architectural state
    logic [COUNT_W-1:0] r_target;
    logic [REC_W-1:0]   r_head;
    logic [REC_W-1:0]   r_tail;
    logic               r_empty;
    logic [COUNT_W-1:0] r_count;
    t_opcode            r_op;
    logic [REC_W-1:0]   r_rec;

    logic [REC_W-1:0]   n_head;
    logic [REC_W-1:0]   n_tail;
    logic               n_empty;
    logic [COUNT_W-1:0] n_count;

    // result register
    logic               r_out_valid;
    logic               r_out_evict;
    logic [REC_W-1:0]   r_out_rec;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_empty;

    logic               ev_valid;
    logic [REC_W-1:0]   ev_rec;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;

    // link memory ports
    logic               nx_we;
    logic [AW-1:0]      nx_waddr;
    logic [REC_W-1:0]   nx_wdata;
    logic [AW-1:0]      nx_raddr;
    logic [REC_W-1:0]   nx_q;
    logic               pv_we;
    logic [AW-1:0]      pv_waddr;
    logic [REC_W-1:0]   pv_wdata;
    logic [AW-1:0]      pv_raddr;
    logic [REC_W-1:0]   pv_q;

    plrp_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (nx_raddr),
        .o_rdata (nx_q)
    );

    plrp_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (pv_raddr),
        .o_rdata (pv_q)
    );

    // add looks up the successor of the head, dequeue the links of its record
    assign nx_raddr = (t_opcode'(i_opcode) == OP_ADD) ? AW'(r_head) : AW'(i_record);
    assign pv_raddr = AW'(i_record);

    assign count_inc = (r_count < COUNT_LIMIT) ? r_count + COUNT_W'(1) : r_count;
    assign count_dec = (r_count != '0) ? r_count - COUNT_W'(1) : r_count;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_empty  = r_empty;
        n_count  = r_count;
        ev_valid = 1'b0;
        ev_rec   = '0;
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;

        // enqueue links the old tail forward during the accept cycle
        if (i_cmd.accept && t_opcode'(i_opcode) == OP_ENQUEUE && rec_ok(i_record)
            && !r_empty && rec_ok(r_tail)) begin
            nx_we    = 1'b1;
            nx_waddr = AW'(r_tail);
            nx_wdata = i_record;
        end

        if (i_cmd.commit) begin
            unique case (r_op)
                OP_ADD: begin
                    n_count = count_inc;
                    if (count_inc > r_target && !r_empty) begin
                        ev_valid = 1'b1;
                        ev_rec   = r_head;
                        n_count  = (count_inc != '0) ? count_inc - COUNT_W'(1) : count_inc;
                        if (rec_ok(r_head)) begin
                            if (r_head == r_tail) begin
                                n_empty = 1'b1;
                                n_head  = '0;
                                n_tail  = '0;
                            end else begin
                                n_head = nx_q;
                            end
                        end
                    end
                end
                OP_FREE: begin
                    n_count = count_dec;
                end
                OP_ENQUEUE: begin
                    if (rec_ok(r_rec)) begin
                        pv_we    = 1'b1;
                        pv_waddr = AW'(r_rec);
                        pv_wdata = r_tail;
                        nx_we    = 1'b1;
                        nx_waddr = AW'(r_rec);
                        // re-enqueue of the tail ends up pointing at itself
                        nx_wdata = (!r_empty && r_tail == r_rec) ? r_rec : '0;
                        if (r_empty) begin
                            n_head = r_rec;
                        end
                        n_tail  = r_rec;
                        n_empty = 1'b0;
                    end
                end
                OP_DEQUEUE: begin
                    if (!r_empty && rec_ok(r_rec)) begin
                        priority if (r_head == r_rec && r_tail == r_rec) begin
                            n_empty = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                        end else if (r_head == r_rec) begin
                            n_head = nx_q;
                        end else if (r_tail == r_rec) begin
                            n_tail = pv_q;
                        end else begin
                            // middle record: splice its neighbors together
                            if (rec_ok(nx_q)) begin
                                pv_we    = 1'b1;
                                pv_waddr = AW'(nx_q);
                                pv_wdata = pv_q;
                            end
                            if (rec_ok(pv_q)) begin
                                nx_we    = 1'b1;
                                nx_waddr = AW'(pv_q);
                                nx_wdata = nx_q;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= COUNT_W'(256);
            r_head      <= '0;
            r_tail      <= '0;
            r_empty     <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_target <= i_cfg.target_size;
            end
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_count <= n_count;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= t_opcode'(i_opcode);
            r_rec <= i_record;
        end
        if (i_cmd.commit) begin
            r_out_evict <= ev_valid;
            r_out_rec   <= ev_rec;
            r_out_count <= n_count;
            r_out_empty <= n_empty;
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign o_status.out_free = !r_out_valid || o_res.ready;

    assign o_res.valid          = r_out_valid;
    assign o_res.evict_valid    = r_out_evict;
    assign o_res.evicted_record = r_out_rec;
    assign o_res.used_count     = r_out_count;
    assign o_res.queue_empty    = r_out_empty;

    `PLRP_ASSERT_IMP(a_count_limit, i_clk, i_rst_n, 1'b1, r_count <= COUNT_LIMIT)
    `PLRP_ASSERT_IMP(a_empty_ends_zero, i_clk, i_rst_n, r_empty, r_head == '0 && r_tail == '0)
    `PLRP_ASSERT_IMP(a_no_evict_rec_zero, i_clk, i_rst_n, r_out_valid && !r_out_evict, r_out_rec == '0)
    `PLRP_ASSERT_NXT(a_commit_sets_valid, i_clk, i_rst_n, i_cmd.commit, r_out_valid)

endmodule

`default_nettype wire

// File: hw/rtl/pinned_lru_record_pool.sv
// ----------------------------------------------------------------------------
// pinned_lru_record_pool
// record pool with used count and an evictable queue kept oldest first
// ----------------------------------------------------------------------------
// Each operation is accepted and then committed: the cycle it is accepted reads
// the next and prev link memories (one read port each), and the commit cycle
// writes the links back, updates head, tail and used count and loads the result
// register. A new operation is accepted in the cycle after that, so the pool
// takes no new operation before the last one is committed; a stalled result
// holds the commit cycle until the result register frees up. The target size
// register may be written at any time the pool is idle and resets to 256.
`default_nettype none

module pinned_lru_record_pool #(
    parameter int RECORDS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    plrp_cmd_if.sink     i_cmd,
    plrp_cfg_if.sink     i_cfg,
    plrp_res_if.source   o_res
);

    import plrp_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_ready;

    plrp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.valid),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    plrp_datapath #(.RECORDS(RECORDS)) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_opcode (i_cmd.opcode),
        .i_record (i_cmd.record),
        .i_cfg    (i_cfg),
        .o_res    (o_res)
    );

    assign i_cmd.ready = w_ready;

endmodule

`default_nettype wire
